// ===== rtl/core/anb2lp_pkg.sv =====
// shared constants, record type and helpers for the annex b to length-prefixed converter
package anb2lp_pkg;

    localparam int ADDR_W      = 48;
    localparam int LEN_W       = 32;
    localparam int TOTAL_W     = 48;
    localparam int BYTE_W      = 8;
    localparam int LEN_BYTES   = 4;
    localparam int MAX_RECS    = 3;
    localparam int PUSH_W      = $clog2(MAX_RECS + 1);
    localparam int FIFO_DEPTH  = 4;
    localparam int FIFO_AW     = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW     = $clog2(FIFO_DEPTH + 1);
    localparam int USER_W      = 3;
    localparam int DATA_W      = ADDR_W + 2 * LEN_W + TOTAL_W;

    localparam logic [LEN_W-1:0]   LEN_MAX     = '1;
    localparam logic [ADDR_W-1:0]  BASE_RESET  = ADDR_W'(16);
    localparam logic [BYTE_W-1:0]  START_BYTE  = BYTE_W'(1);

    typedef enum logic [1:0] {
        KIND_PAYLOAD  = 2'd0,
        KIND_ZERO_RUN = 2'd1,
        KIND_LENGTH   = 2'd2
    } kind_t;

    typedef struct packed {
        kind_t               kind;
        logic [ADDR_W-1:0]   addr;
        logic [LEN_W-1:0]    value;
        logic [LEN_W-1:0]    run_count;
        logic [TOTAL_W-1:0]  total;
        logic                done;
        logic                last;
    } record_t;

    function automatic record_t make_rec(kind_t k, logic [ADDR_W-1:0] a, logic [LEN_W-1:0] v,
                                         logic [LEN_W-1:0] r, logic [TOTAL_W-1:0] t);
        record_t rec;
        rec.kind      = k;
        rec.addr      = a;
        rec.value     = v;
        rec.run_count = r;
        rec.total     = t;
        rec.done      = 1'b0;
        rec.last      = 1'b0;
        return rec;
    endfunction

endpackage

// ===== rtl/core/anb2lp_step.sv =====
// per-word parser state and record generation for one input byte
module anb2lp_step (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_accept,
    input  logic [anb2lp_pkg::BYTE_W-1:0]          data_byte,
    input  logic                                   end_of_unit,
    input  logic                                   cfg_we,
    input  logic [anb2lp_pkg::ADDR_W-1:0]          cfg_data,
    output anb2lp_pkg::record_t [anb2lp_pkg::MAX_RECS-1:0] recs,
    output logic [anb2lp_pkg::PUSH_W-1:0]          push_n
);
    import anb2lp_pkg::*;

    logic [LEN_W-1:0]    zr_reg,   zr_next;
    logic                nal_reg,  nal_next;
    logic [ADDR_W-1:0]   addr_reg, addr_next;
    logic [ADDR_W-1:0]   lfa_reg,  lfa_next;
    logic [LEN_W-1:0]    len_reg,  len_next;
    logic [TOTAL_W-1:0]  ub_reg,   ub_next;

    logic                is_zero;
    logic                start_code;
    logic [LEN_W-1:0]    zr_inc;
    logic [LEN_W-1:0]    fz;
    logic [ADDR_W-1:0]   addr_flush;
    logic [ADDR_W-1:0]   addr_byte;
    logic [TOTAL_W-1:0]  ub_flush;
    logic [TOTAL_W-1:0]  ub_byte;
    logic [LEN_W:0]      len_sum;
    logic [LEN_W-1:0]    len1;
    logic [LEN_W-1:0]    len2;

    assign is_zero    = (data_byte == '0);
    assign start_code = (data_byte == START_BYTE) && (zr_reg >= LEN_W'(2));
    assign zr_inc     = (zr_reg == LEN_MAX) ? zr_reg : zr_reg + LEN_W'(1);
    assign fz         = is_zero ? zr_inc : zr_reg;
    assign addr_flush = addr_reg + ADDR_W'(fz);
    assign addr_byte  = addr_flush + ADDR_W'(1);
    assign ub_flush   = ub_reg + TOTAL_W'(fz);
    assign ub_byte    = ub_flush + TOTAL_W'(1);
    assign len_sum    = {1'b0, len_reg} + {1'b0, fz};
    assign len1       = len_sum[LEN_W] ? LEN_MAX : len_sum[LEN_W-1:0];
    assign len2       = (len1 == LEN_MAX) ? LEN_MAX : len1 + LEN_W'(1);

    // records for this byte, packed from slot 0
    always_comb
    begin
        recs   = '0;
        push_n = '0;
        if (start_code)
        begin
            if (nal_reg)
            begin
                recs[0] = make_rec(KIND_LENGTH, lfa_reg, len_reg, '0, ub_reg);
                push_n  = PUSH_W'(1);
            end
        end
        else if (is_zero)
        begin
            if (end_of_unit && nal_reg)
            begin
                recs[0] = make_rec(KIND_ZERO_RUN, addr_reg, '0, fz, ub_flush);
                recs[1] = make_rec(KIND_LENGTH, lfa_reg, len1, '0, ub_flush);
                push_n  = PUSH_W'(2);
            end
        end
        else if (nal_reg)
        begin
            if (zr_reg != '0)
            begin
                recs[push_n] = make_rec(KIND_ZERO_RUN, addr_reg, '0, zr_reg, ub_flush);
                push_n       = push_n + PUSH_W'(1);
            end
            recs[push_n] = make_rec(KIND_PAYLOAD, addr_flush, LEN_W'(data_byte), '0, ub_byte);
            push_n       = push_n + PUSH_W'(1);
            if (end_of_unit)
            begin
                recs[push_n] = make_rec(KIND_LENGTH, lfa_reg, len2, '0, ub_byte);
                push_n       = push_n + PUSH_W'(1);
            end
        end
        if (push_n != '0)
        begin
            recs[push_n - PUSH_W'(1)].last = 1'b1;
            recs[push_n - PUSH_W'(1)].done = end_of_unit;
        end
    end

    always_comb
    begin
        zr_next   = zr_reg;
        nal_next  = nal_reg;
        addr_next = addr_reg;
        lfa_next  = lfa_reg;
        len_next  = len_reg;
        ub_next   = ub_reg;
        if (start_code)
        begin
            zr_next  = '0;
            nal_next = 1'b0;
            if (!end_of_unit)
            begin
                lfa_next  = addr_reg;
                addr_next = addr_reg + ADDR_W'(LEN_BYTES);
                ub_next   = ub_reg + TOTAL_W'(LEN_BYTES);
                len_next  = '0;
                nal_next  = 1'b1;
            end
        end
        else if (is_zero)
        begin
            zr_next = zr_inc;
            if (end_of_unit && nal_reg)
            begin
                addr_next = addr_flush;
                ub_next   = ub_flush;
                len_next  = len1;
            end
        end
        else
        begin
            zr_next = '0;
            if (nal_reg)
            begin
                addr_next = addr_byte;
                ub_next   = ub_byte;
                len_next  = len2;
            end
        end
        if (end_of_unit)
        begin
            zr_next  = '0;
            nal_next = 1'b0;
            ub_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zr_reg   <= '0;
            nal_reg  <= 1'b0;
            addr_reg <= BASE_RESET;
            lfa_reg  <= '0;
            len_reg  <= '0;
            ub_reg   <= '0;
        end
        else if (cfg_we)
        begin
            addr_reg <= cfg_data;
        end
        else if (in_accept)
        begin
            zr_reg   <= zr_next;
            nal_reg  <= nal_next;
            addr_reg <= addr_next;
            lfa_reg  <= lfa_next;
            len_reg  <= len_next;
            ub_reg   <= ub_next;
        end
    end

    a_start_clears_run: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && !cfg_we && start_code) |=> (zr_reg == '0))
        else $error("zero run not cleared after start code");

    a_eou_clears_unit: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && !cfg_we && end_of_unit) |=> (!nal_reg && ub_reg == '0))
        else $error("unit state not cleared at end of unit");

    a_no_rec_outside_nal: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && !nal_reg) |-> (push_n == '0))
        else $error("record produced with no open nal");

endmodule

// ===== rtl/core/anb2lp_fifo.sv =====
// record queue that takes up to three records a cycle and gives one while the sink is ready
module anb2lp_fifo (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  anb2lp_pkg::record_t [anb2lp_pkg::MAX_RECS-1:0] recs,
    input  logic [anb2lp_pkg::PUSH_W-1:0]          push_n,
    output logic                                   room,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output anb2lp_pkg::record_t                    out_rec
);
    import anb2lp_pkg::*;

    record_t             mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]  wptr_reg, wptr_next;
    logic [FIFO_AW-1:0]  rptr_reg, rptr_next;
    logic [FIFO_CW-1:0]  count_reg, count_next;
    logic                pop;

    assign out_valid = (count_reg != '0);
    assign out_rec   = mem_reg[rptr_reg];
    assign pop       = out_valid && out_ready;
    // room for a full set of records whatever the sink does
    assign room      = (count_reg <= FIFO_CW'(FIFO_DEPTH - MAX_RECS));

    assign wptr_next  = wptr_reg + FIFO_AW'(push_n);
    assign rptr_next  = rptr_reg + FIFO_AW'(pop);
    assign count_next = count_reg + FIFO_CW'(push_n) - FIFO_CW'(pop);

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_RECS; i++)
        begin
            if (PUSH_W'(i) < push_n)
            begin
                mem_reg[wptr_reg + FIFO_AW'(i)] <= recs[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FIFO_CW'(FIFO_DEPTH))
        else $error("record queue overflow");

    a_push_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        (push_n != '0) |-> room)
        else $error("records pushed without room");

    a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_rec.done) |-> out_rec.last)
        else $error("unit end on a record that is not the last of its word");

    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && count_reg == FIFO_CW'(1) && push_n == '0) |=> !out_valid)
        else $error("queue not empty after last record taken");

endmodule

// ===== rtl/core/annexb_to_length_prefixed_nal_top.sv =====
// top level: annex b byte stream in, length-prefixed nal write records out
// output: each record is registered in the record queue before the master side sees it
// throughput: one byte a cycle while each byte makes at most one record and the
//   master side is ready; a byte making two or three records holds the next byte back
//   until the one-record-per-cycle output has drained the four-entry record queue to one record
// reset: queue empty, parser outside any nal, output address at 16
module annexb_to_length_prefixed_nal_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [anb2lp_pkg::BYTE_W-1:0]       s_tdata,   // data_byte
    input  logic                                s_tlast,   // end_of_unit
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [anb2lp_pkg::DATA_W-1:0]       m_tdata,   // write_address, value, run_count, unit_total
    output logic [anb2lp_pkg::USER_W-1:0]       m_tuser,   // record_kind, unit_done
    output logic                                m_tlast,   // last_of_run
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [anb2lp_pkg::ADDR_W-1:0]       cfg_data   // base_offset
);
    import anb2lp_pkg::*;

    record_t [MAX_RECS-1:0]  recs;
    logic [PUSH_W-1:0]       push_cnt;
    logic [PUSH_W-1:0]       push_n;
    logic                    room;
    logic                    in_accept;
    record_t                 out_rec;

    assign cfg_ready = 1'b1;
    // a register write takes the cycle, no byte alongside it
    assign s_tready  = room && !cfg_valid;
    assign in_accept = s_tvalid && s_tready;
    assign push_n    = in_accept ? push_cnt : '0;

    anb2lp_step u_step (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_accept   (in_accept),
        .data_byte   (s_tdata),
        .end_of_unit (s_tlast),
        .cfg_we      (cfg_valid && cfg_ready),
        .cfg_data    (cfg_data),
        .recs        (recs),
        .push_n      (push_cnt)
    );

    anb2lp_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .recs      (recs),
        .push_n    (push_n),
        .room      (room),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_rec   (out_rec)
    );

    assign m_tdata = {out_rec.total, out_rec.run_count, out_rec.value, out_rec.addr};
    assign m_tuser = {out_rec.done, out_rec.kind};
    assign m_tlast = out_rec.last;

endmodule
